[rtl/ffd_pkg.sv]
package ffd_pkg;

   // Field and state widths.
   localparam int CHAN_W  = 8;
   localparam int PX_W    = 10;
   localparam int FRAME_W = 30;
   localparam int DIFF_W  = 31;
   localparam int VAR_W   = 48;
   localparam int COEF_W  = 8;
   localparam int THR_W   = VAR_W + COEF_W;
   localparam int FSEEN_W = 2;

   // Configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = VAR_W;
   localparam logic [CSR_IDX_W-1:0] CSR_REFERENCE_SUM     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGNIFICANCE_COEF = 1'd1;
   localparam logic [COEF_W-1:0]    COEF_RESET            = 8'd50;

   // Input item kinds.
   localparam logic KIND_PIXEL  = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   // Result queue.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [VAR_W-1:0] variation_sum;
      logic             emitter_working;
      logic             no_frames;
   } rsp_type;

endpackage

[rtl/frame_flicker_detector_core.sv]
// Frame flicker detector. Pixels (req_kind = 0) are summed over their three channels into a
// saturating per-frame total; the pixel with req_frame_end = 1 closes the frame. From the
// second closed frame on, the difference between consecutive frame totals is formed, and
// from the second difference on the absolute change between differences is added to a
// 48-bit saturating variation sum. A report item (req_kind = 1) returns the sum, a flag
// telling whether it exceeds reference_sum * significance_coef, and a flag for a window
// without any closed frame, then clears all frame state (configuration is kept). The block
// takes one item per clock; each item passes a four-stage pipeline (input register, frame
// accumulator, difference stage, variation accumulator), and a report's result enters the
// queue as the report leaves the variation accumulator. Results wait in a four-entry queue; input is
// held off only while four reports are accepted but not yet transferred out.
module frame_flicker_detector_core
   import ffd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [CHAN_W-1:0]     req_chan_a,
   input  logic [CHAN_W-1:0]     req_chan_b,
   input  logic [CHAN_W-1:0]     req_chan_c,
   input  logic                  req_frame_end,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [VAR_W-1:0]      rsp_variation_sum,
   output logic                  rsp_emitter_working,
   output logic                  rsp_no_frames
);

   // Configuration registers and the derived threshold.
   logic [VAR_W-1:0]  reference_sum_ff;
   logic [COEF_W-1:0] significance_coef_ff;
   logic [THR_W-1:0]  threshold_ff, threshold_in;

   // Stage A: accepted item.
   logic              a_valid_ff, a_valid_in;
   logic              a_report_ff;
   logic              a_end_ff;
   logic [PX_W-1:0]   a_px_ff, a_px_in;

   // Stage B: frame accumulation.
   logic [FRAME_W-1:0] frame_total_ff, frame_total_in;
   logic               b_valid_ff, b_valid_in;
   logic               b_report_ff, b_report_in;
   logic [FRAME_W-1:0] b_total_ff, b_total_in;
   logic [FRAME_W:0]   frame_sum;
   logic [FRAME_W-1:0] frame_sat;

   // Stage C: frame differences.
   logic [FRAME_W-1:0]       previous_total_ff, previous_total_in;
   logic signed [DIFF_W-1:0] previous_diff_ff, previous_diff_in;
   logic [FSEEN_W-1:0]       frames_seen_ff, frames_seen_in;
   logic                     c_valid_ff, c_valid_in;
   logic                     c_report_ff, c_report_in;
   logic                     c_add_en_ff, c_add_en_in;
   logic [DIFF_W-1:0]        c_add_ff, c_add_in;
   logic                     c_no_frames_ff, c_no_frames_in;
   logic signed [DIFF_W-1:0] frame_diff;
   logic signed [DIFF_W:0]   second_diff;

   // Stage D: variation accumulation.
   logic [VAR_W-1:0] running_variation_ff, running_variation_in;
   logic [VAR_W:0]   variation_sum_wide;
   logic             d_push;
   rsp_type          d_entry;

   // Result queue and report credit.
   rsp_type              rsp_mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic [RSP_CNT_W-1:0] pending_ff, pending_in;
   logic                 req_xfer;
   logic                 rsp_pop;

   // Handshakes. A report takes a queue slot when it is accepted.
   assign req_ready = (pending_ff != RSP_CNT_W'(RSP_DEPTH));
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_pop   = rsp_valid && rsp_ready;

   assign rsp_variation_sum   = rsp_mem_ff[rd_ptr_ff].variation_sum;
   assign rsp_emitter_working = rsp_mem_ff[rd_ptr_ff].emitter_working;
   assign rsp_no_frames       = rsp_mem_ff[rd_ptr_ff].no_frames;

   // The registered threshold follows the configuration in the next cycle.
   assign threshold_in = THR_W'(reference_sum_ff) * THR_W'(significance_coef_ff);

   // Stage A: pixel intensity is formed on the way in.
   assign a_valid_in = req_xfer;
   assign a_px_in    = PX_W'(req_chan_a) + PX_W'(req_chan_b) + PX_W'(req_chan_c);

   // Stage B: saturating frame total; close the frame or clear on a report.
   assign frame_sum = {1'b0, frame_total_ff} + (FRAME_W + 1)'(a_px_ff);
   assign frame_sat = frame_sum[FRAME_W] ? '1 : frame_sum[FRAME_W-1:0];

   always_comb begin
      frame_total_in = frame_total_ff;
      b_valid_in     = 1'b0;
      b_report_in    = 1'b0;
      b_total_in     = frame_sat;
      if (a_valid_ff) begin
         if (a_report_ff == KIND_REPORT) begin
            frame_total_in = '0;
            b_valid_in     = 1'b1;
            b_report_in    = 1'b1;
         end else if (a_end_ff) begin
            frame_total_in = '0;
            b_valid_in     = 1'b1;
         end else begin
            frame_total_in = frame_sat;
         end
      end
   end

   // Stage C: difference of frame totals and its change from the last difference.
   assign frame_diff  = $signed({1'b0, previous_total_ff}) - $signed({1'b0, b_total_ff});
   assign second_diff = $signed({previous_diff_ff[DIFF_W-1], previous_diff_ff})
                        - $signed({frame_diff[DIFF_W-1], frame_diff});

   always_comb begin
      previous_total_in = previous_total_ff;
      previous_diff_in  = previous_diff_ff;
      frames_seen_in    = frames_seen_ff;
      c_valid_in        = b_valid_ff;
      c_report_in       = b_report_ff;
      c_add_en_in       = 1'b0;
      c_add_in          = second_diff[DIFF_W] ? DIFF_W'(-second_diff)
                                              : second_diff[DIFF_W-1:0];
      c_no_frames_in    = (frames_seen_ff == '0);
      if (b_valid_ff) begin
         if (b_report_ff) begin
            previous_total_in = '0;
            previous_diff_in  = '0;
            frames_seen_in    = '0;
         end else begin
            if (frames_seen_ff != '0) begin
               previous_diff_in = frame_diff;
            end
            c_add_en_in       = frames_seen_ff[1];
            previous_total_in = b_total_ff;
            if (frames_seen_ff != '1) begin
               frames_seen_in = frames_seen_ff + 1'b1;
            end
         end
      end
   end

   // Stage D: saturating variation sum; a report pushes a result and clears the sum.
   assign variation_sum_wide = {1'b0, running_variation_ff} + (VAR_W + 1)'(c_add_ff);
   assign d_push = c_valid_ff && c_report_ff;

   always_comb begin
      d_entry.variation_sum   = running_variation_ff;
      d_entry.emitter_working = (THR_W'(running_variation_ff) > threshold_ff);
      d_entry.no_frames       = c_no_frames_ff;
      running_variation_in    = running_variation_ff;
      if (d_push) begin
         running_variation_in = '0;
      end else if (c_valid_ff && c_add_en_ff) begin
         running_variation_in = variation_sum_wide[VAR_W] ? '1 : variation_sum_wide[VAR_W-1:0];
      end
   end

   // Queue pointers and report credit.
   always_comb begin
      wr_ptr_in  = d_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = rsp_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff + RSP_CNT_W'(d_push) - RSP_CNT_W'(rsp_pop);
      pending_in = pending_ff + RSP_CNT_W'(req_xfer && (req_kind == KIND_REPORT))
                   - RSP_CNT_W'(rsp_pop);
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         reference_sum_ff     <= '0;
         significance_coef_ff <= COEF_RESET;
         a_valid_ff           <= 1'b0;
         b_valid_ff           <= 1'b0;
         c_valid_ff           <= 1'b0;
         frame_total_ff       <= '0;
         previous_total_ff    <= '0;
         previous_diff_ff     <= '0;
         frames_seen_ff       <= '0;
         running_variation_ff <= '0;
         wr_ptr_ff            <= '0;
         rd_ptr_ff            <= '0;
         count_ff             <= '0;
         pending_ff           <= '0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_REFERENCE_SUM:     reference_sum_ff     <= csr_wdata[VAR_W-1:0];
               CSR_SIGNIFICANCE_COEF: significance_coef_ff <= csr_wdata[COEF_W-1:0];
               default: ;
            endcase
         end
         a_valid_ff           <= a_valid_in;
         b_valid_ff           <= b_valid_in;
         c_valid_ff           <= c_valid_in;
         frame_total_ff       <= frame_total_in;
         previous_total_ff    <= previous_total_in;
         previous_diff_ff     <= previous_diff_in;
         frames_seen_ff       <= frames_seen_in;
         running_variation_ff <= running_variation_in;
         wr_ptr_ff            <= wr_ptr_in;
         rd_ptr_ff            <= rd_ptr_in;
         count_ff             <= count_in;
         pending_ff           <= pending_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      threshold_ff   <= threshold_in;
      a_report_ff    <= req_kind;
      a_end_ff       <= req_frame_end;
      a_px_ff        <= a_px_in;
      b_report_ff    <= b_report_in;
      b_total_ff     <= b_total_in;
      c_report_ff    <= c_report_in;
      c_add_en_ff    <= c_add_en_in;
      c_add_ff       <= c_add_in;
      c_no_frames_ff <= c_no_frames_in;
      if (d_push) begin
         rsp_mem_ff[wr_ptr_ff] <= d_entry;
      end
   end

   // The queue never takes a result while it is full.
   assert property (@(posedge clock) disable iff (reset)
      (d_push && !rsp_pop) |-> (count_ff != RSP_CNT_W'(RSP_DEPTH)))
      else $error("result queue overflow");

   // Every queued result belongs to an accepted report.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= pending_ff)
      else $error("queued results exceed accepted reports");

   // Before the second closed frame no difference is held.
   assert property (@(posedge clock) disable iff (reset)
      (frames_seen_ff[1] == 1'b0) |-> (previous_diff_ff == '0))
      else $error("frame difference present before two frames");

   // A window without frames carries no variation.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_frames) |-> (rsp_variation_sum == '0 && !rsp_emitter_working))
      else $error("empty window reports variation");

   // A transfer out frees exactly one report credit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !req_xfer) |=> (pending_ff == $past(pending_ff) - 1'b1))
      else $error("report credit not returned");

endmodule
